### hdl/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types and constants of the prime sieve sum query block.
// ----------------------------------------------------------------------------
package pss_pkg;

    localparam int MAX_LIMIT_DEF = 4096;
    localparam int LIMIT_W       = 13;
    localparam int COUNT_W       = 13;
    localparam int SUM_W         = 24;
    localparam int SUM_LIM       = 2 ** SUM_W;   // first value past saturation

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4096);
    localparam logic [SUM_W-1:0]   SUM_MAX     = {SUM_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_TEST,
        ST_CHECK,
        ST_MARK,
        ST_NEXT,
        ST_WALK,
        ST_DONE
    } t_state;

    // Bitmap control from sequencer to memory
    typedef struct packed {
        logic wr;
        logic wbit;
    } t_map_ctl;

    typedef struct packed {
        logic               short_flag;
        logic [COUNT_W-1:0] primes_used;
        logic [SUM_W-1:0]   prime_sum;
    } t_result;

endpackage

### hdl/pss_alu.sv
// ----------------------------------------------------------------------------
// pss_alu
// Shared adder with a less-than compare of the sum against a bound.
// ----------------------------------------------------------------------------
module pss_alu #(
    parameter int DW = 25
) (
    input  logic [DW-1:0] i_a,
    input  logic [DW-1:0] i_b,
    input  logic [DW-1:0] i_bound,
    output logic [DW-1:0] o_sum,
    output logic          o_lt
);
    assign o_sum = i_a + i_b;
    assign o_lt  = (o_sum < i_bound);
endmodule

### hdl/pss_map.sv
// ----------------------------------------------------------------------------
// pss_map
// Single-port composite bitmap, one bit per number, registered read.
// ----------------------------------------------------------------------------
module pss_map #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic             i_clk,
    input  pss_pkg::t_map_ctl i_ctl,
    input  logic [AW-1:0]    i_addr,
    output logic             o_rdata
);
    import pss_pkg::*;

    logic r_mem [DEPTH];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_addr] <= i_ctl.wbit;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

### hdl/pss_seq.sv
// ----------------------------------------------------------------------------
// pss_seq
// Sequencer: clears and sieves the bitmap, then walks it to sum primes.
// ----------------------------------------------------------------------------
module pss_seq #(
    parameter int CW = 13,
    parameter int AW = 12,
    parameter int DW = 25
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr,
    input  logic                        i_start,
    input  logic [pss_pkg::COUNT_W-1:0] i_count,
    input  logic [CW-1:0]               i_lim,
    output logic                        o_idle,
    output logic                        o_res_valid,
    input  logic                        i_res_take,
    output pss_pkg::t_result            o_res,
    output pss_pkg::t_map_ctl           o_map_ctl,
    output logic [AW-1:0]               o_map_addr,
    input  logic                        i_map_rdata,
    output logic [DW-1:0]               o_alu_a,
    output logic [DW-1:0]               o_alu_b,
    output logic [DW-1:0]               o_alu_bound,
    input  logic [DW-1:0]               i_alu_sum,
    input  logic                        i_alu_lt
);
    import pss_pkg::*;

    t_state             r_state, n_state;
    logic               r_built, n_built;
    logic [CW-1:0]      r_lim, n_lim;
    logic [COUNT_W-1:0] r_want, n_want;
    logic [CW-1:0]      r_v, n_v;
    logic [CW-1:0]      r_i, n_i;
    logic [DW-1:0]      r_sq, n_sq;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [COUNT_W-1:0] r_used, n_used;
    logic               r_pend, n_pend;
    logic [CW-1:0]      r_pend_v, n_pend_v;
    logic               v_in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_built <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_built <= n_built;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lim    <= n_lim;
        r_want   <= n_want;
        r_v      <= n_v;
        r_i      <= n_i;
        r_sq     <= n_sq;
        r_sum    <= n_sum;
        r_used   <= n_used;
        r_pend_v <= n_pend_v;
    end

    assign v_in_range = (r_v < r_lim);

    always_comb begin
        n_state     = r_state;
        n_built     = r_built;
        n_lim       = r_lim;
        n_want      = r_want;
        n_v         = r_v;
        n_i         = r_i;
        n_sq        = r_sq;
        n_sum       = r_sum;
        n_used      = r_used;
        n_pend      = r_pend;
        n_pend_v    = r_pend_v;
        o_idle      = 1'b0;
        o_res_valid = 1'b0;
        o_map_ctl   = '0;
        o_map_addr  = r_v[AW-1:0];
        o_alu_a     = DW'(r_v);
        o_alu_b     = DW'(1);
        o_alu_bound = DW'(r_lim);

        unique case (r_state)
            ST_IDLE: begin
                o_idle = 1'b1;
                if (i_start) begin
                    n_want = i_count;
                    n_lim  = i_lim;
                    n_sum  = '0;
                    n_used = '0;
                    n_pend = 1'b0;
                    if (r_built) begin
                        n_v     = CW'(2);
                        n_state = ST_WALK;
                    end else begin
                        n_v     = '0;
                        n_state = ST_CLEAR;
                    end
                end
            end
            ST_CLEAR: begin
                // write 1 for 0 and 1, 0 elsewhere
                o_map_ctl.wr   = 1'b1;
                o_map_ctl.wbit = (r_v < CW'(2));
                if (i_alu_lt) begin
                    n_v = i_alu_sum[CW-1:0];
                end else begin
                    n_i     = CW'(2);
                    n_sq    = DW'(4);
                    n_state = ST_TEST;
                end
            end
            ST_TEST: begin
                o_alu_a    = r_sq;
                o_alu_b    = '0;
                o_map_addr = r_i[AW-1:0];
                if (i_alu_lt) begin
                    n_state = ST_CHECK;
                end else begin
                    n_built = 1'b1;
                    n_v     = CW'(2);
                    n_state = ST_WALK;
                end
            end
            ST_CHECK: begin
                if (i_map_rdata) begin
                    n_state = ST_NEXT;
                end else begin
                    n_v     = r_sq[CW-1:0];
                    n_state = ST_MARK;
                end
            end
            ST_MARK: begin
                o_map_ctl.wr   = 1'b1;
                o_map_ctl.wbit = 1'b1;
                o_alu_b        = DW'(r_i);
                if (i_alu_lt) begin
                    n_v = i_alu_sum[CW-1:0];
                end else begin
                    n_state = ST_NEXT;
                end
            end
            ST_NEXT: begin
                // (i+1)^2 = i^2 + 2i + 1
                o_alu_a = r_sq;
                o_alu_b = DW'({r_i, 1'b1});
                n_sq    = i_alu_sum;
                n_i     = r_i + CW'(1);
                n_state = ST_TEST;
            end
            ST_WALK: begin
                o_alu_a     = DW'(r_sum);
                o_alu_b     = DW'(r_pend_v);
                o_alu_bound = DW'(SUM_LIM);
                // issue the next bitmap read
                n_pend   = v_in_range;
                n_pend_v = r_v;
                if (v_in_range) begin
                    n_v = r_v + CW'(1);
                end
                // accumulate the number whose bit was read last cycle
                if (r_pend && !i_map_rdata && (r_used < r_want)) begin
                    n_sum  = i_alu_lt ? i_alu_sum[SUM_W-1:0] : SUM_MAX;
                    n_used = r_used + COUNT_W'(1);
                end
                if ((r_used == r_want) || (!r_pend && !v_in_range)) begin
                    n_pend  = 1'b0;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (i_cfg_wr) begin
            n_built = 1'b0;
        end
    end

    assign o_res.prime_sum   = r_sum;
    assign o_res.primes_used = r_used;
    assign o_res.short_flag  = (r_used < r_want);
endmodule

### hdl/prime_sieve_sum_query_top.sv
// ----------------------------------------------------------------------------
// prime_sieve_sum_query_top
// Sum of the first n primes below a configured limit, from a sieve bitmap.
// ----------------------------------------------------------------------------
// A query transfer carries a count n; the result transfer carries the sum of
// the first n primes below the limit (saturating at 2^24-1), how many primes
// were added, and a flag set when fewer than n exist. The limit in use is
// capped at MAX_LIMIT. The first query after reset or after any limit write
// rebuilds the bitmap: a clearing sweep of one number per cycle up to the
// limit, then for each i with i*i below the limit one test read and, for a
// prime i, one marking write per multiple. Every query then walks the bitmap
// from 2 at one number per cycle, stopping once n primes are summed or the
// limit is reached. Each i tested passes through test and check states,
// marking states for a prime i, and a next state. All of this is bounded by
// the single-port bitmap memory, one access per cycle. The query side is
// not ready while a query is in progress; a finished result waits in an
// output register, and the next query is taken while it waits. A second
// finished result holds the sequencer until the output register drains.
// ----------------------------------------------------------------------------
module prime_sieve_sum_query_top #(
    parameter int MAX_LIMIT = pss_pkg::MAX_LIMIT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [pss_pkg::LIMIT_W-1:0] i_cfg_wdata,  // sieve_limit
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [15:0]                 s_axis_tdata,  // prime_count[12:0], zero pad
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [39:0]                 m_axis_tdata   // prime_sum[23:0],
                                                       // primes_used[36:24],
                                                       // short_flag[37], zero pad
);
    import pss_pkg::*;

    localparam int VW = $clog2(MAX_LIMIT + 1);
    localparam int CW = (VW > LIMIT_W) ? VW : LIMIT_W;
    localparam int AW = $clog2(MAX_LIMIT);
    localparam int DW = ((SUM_W + 1) > (CW + 2)) ? (SUM_W + 1) : (CW + 2);

    logic [LIMIT_W-1:0] r_limit;
    logic [CW-1:0]      limit_ext;
    logic [CW-1:0]      active_lim;
    logic               r_out_valid;
    t_result            r_out;

    logic               seq_idle;
    logic               res_valid;
    logic               res_take;
    t_result            res;
    t_map_ctl           map_ctl;
    logic [AW-1:0]      map_addr;
    logic               map_rdata;
    logic [DW-1:0]      alu_a, alu_b, alu_bound, alu_sum;
    logic               alu_lt;
    logic               q_accept;

    // Limit register: any write marks the bitmap stale inside the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // Cap the limit at the bitmap depth
    assign limit_ext  = CW'(r_limit);
    assign active_lim = (limit_ext > CW'(MAX_LIMIT)) ? CW'(MAX_LIMIT) : limit_ext;

    assign s_axis_tready = seq_idle;
    assign q_accept      = s_axis_tvalid && seq_idle;

    // Hand the result over once the output register is free or draining
    assign res_take = res_valid && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out};

    pss_seq #(
        .CW (CW),
        .AW (AW),
        .DW (DW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_we),
        .i_start     (q_accept),
        .i_count     (s_axis_tdata[COUNT_W-1:0]),
        .i_lim       (active_lim),
        .o_idle      (seq_idle),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res),
        .o_map_ctl   (map_ctl),
        .o_map_addr  (map_addr),
        .i_map_rdata (map_rdata),
        .o_alu_a     (alu_a),
        .o_alu_b     (alu_b),
        .o_alu_bound (alu_bound),
        .i_alu_sum   (alu_sum),
        .i_alu_lt    (alu_lt)
    );

    pss_alu #(
        .DW (DW)
    ) u_alu (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_bound (alu_bound),
        .o_sum   (alu_sum),
        .o_lt    (alu_lt)
    );

    pss_map #(
        .DEPTH (MAX_LIMIT),
        .AW    (AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_ctl   (map_ctl),
        .i_addr  (map_addr),
        .o_rdata (map_rdata)
    );
endmodule

### hdl/pss_chk.sv
// ----------------------------------------------------------------------------
// pss_chk
// Port-level checks of the prime sieve sum query block.
// ----------------------------------------------------------------------------
module pss_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);
    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A query occupies the block: the query side is not ready straight after a transfer
    a_busy_after_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("query side ready straight after a transfer");

    // Sum is zero exactly when no prime was added
    a_sum_vs_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[36:24] == 13'd0) == (m_axis_tdata[23:0] == 24'd0)))
        else $error("sum inconsistent with prime count");

    // Reset leaves no result pending and the query side open
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("block not idle after reset");
endmodule

bind prime_sieve_sum_query_top pss_chk u_pss_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the prime sieve sum query block.
// ----------------------------------------------------------------------------
// Query transfers carry a prime count. An in-bench sieve works out the sum of
// the first n primes below the current limit for every accepted query. Result
// transfers are then compared field by field, in order, against those sums.
// The limit register is rewritten between phases, only once the block has
// drained. The phases cover limits below 2, small limits, the reset limit and
// limits above the cap. Query bursts and gaps are random, the result side
// stalls on a pattern of its own, and one long result hold-off fills the
// block until it stalls its query side.
// ----------------------------------------------------------------------------
module testbench;
    import pss_pkg::*;

    localparam int          RUN_LIMIT  = 4_000_000;  // cycles before giving up
    localparam int          HOLD_LEN   = 400;        // long result hold-off
    localparam int          TAIL_LEN   = 200;        // quiet cycles at the end
    localparam int          RESULT_W   = $bits(t_result);
    localparam int unsigned COUNT_MAX  = 2 ** COUNT_W - 1;
    localparam int unsigned LIMIT_MAX  = 2 ** LIMIT_W - 1;

    // Result side stall patterns
    typedef enum int {
        RX_OPEN,    // always ready
        RX_COIN,    // ready half the time
        RX_SPARSE,  // ready one cycle in eight
        RX_BEAT     // two ready cycles in five
    } t_rx_mode;

    // ------------------------------------------------------------------------
    // Sieve model and store of sums still owed by the block
    // ------------------------------------------------------------------------
    class sieve_sums;
        bit [LIMIT_W-1:0] limit_reg;
        bit               map_stale;
        bit               composite [MAX_LIMIT_DEF];
        t_result          sums_due [$];
        int               n_errors;

        function new();
            limit_reg = LIMIT_RESET;
            map_stale = 1'b1;
            n_errors  = 0;
        endfunction

        // Any write marks the bitmap for rebuilding, even with the same value
        function void write_limit(bit [LIMIT_W-1:0] value);
            limit_reg = value;
            map_stale = 1'b1;
        endfunction

        function int unsigned span();
            return (limit_reg > MAX_LIMIT_DEF) ? MAX_LIMIT_DEF : limit_reg;
        endfunction

        function void build_map();
            int unsigned lim;
            int unsigned i;
            int unsigned k;
            lim = span();
            foreach (composite[j])
                composite[j] = 1'b0;
            if (lim > 0)
                composite[0] = 1'b1;
            if (lim > 1)
                composite[1] = 1'b1;
            for (i = 2; i * i < lim; i++) begin
                if (!composite[i]) begin
                    for (k = i * i; k < lim; k += i)
                        composite[k] = 1'b1;
                end
            end
            map_stale = 1'b0;
        endfunction

        // Walk the bitmap from 2, adding primes until the count is met or the limit is reached
        function void note_query(bit [COUNT_W-1:0] want);
            int unsigned lim;
            int unsigned v;
            int unsigned used;
            int unsigned sum;
            t_result     r;
            if (map_stale)
                build_map();
            lim  = span();
            used = 0;
            sum  = 0;
            for (v = 2; v < lim && used < want; v++) begin
                if (!composite[v]) begin
                    sum += v;
                    if (sum > SUM_MAX)
                        sum = SUM_MAX;
                    used++;
                end
            end
            r.prime_sum   = sum[SUM_W-1:0];
            r.primes_used = used[COUNT_W-1:0];
            r.short_flag  = (used < want);
            sums_due.push_back(r);
        endfunction

        function void check_result(logic [39:0] data);
            t_result due;
            t_result got;
            if (sums_due.size() == 0) begin
                $error("result transfer with no query outstanding: tdata=%h", data);
                n_errors++;
                return;
            end
            due = sums_due.pop_front();
            got = t_result'(data[RESULT_W-1:0]);
            if (got.prime_sum !== due.prime_sum) begin
                $error("prime_sum: expected %0d, got %0d", due.prime_sum, got.prime_sum);
                n_errors++;
            end
            if (got.primes_used !== due.primes_used) begin
                $error("primes_used: expected %0d, got %0d",
                       due.primes_used, got.primes_used);
                n_errors++;
            end
            if (got.short_flag !== due.short_flag) begin
                $error("short_flag: expected %0d, got %0d", due.short_flag, got.short_flag);
                n_errors++;
            end
            if (data[39:RESULT_W] !== '0) begin
                $error("pad: expected 0, got %0h", data[39:RESULT_W]);
                n_errors++;
            end
        endfunction

        function int pending();
            return sums_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs (all known from time zero)
    // ------------------------------------------------------------------------
    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_cfg_we       = 1'b0;
    logic [LIMIT_W-1:0] i_cfg_wdata    = '0;
    logic               s_axis_tvalid  = 1'b0;
    logic               s_axis_tready;
    logic [15:0]        s_axis_tdata   = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready  = 1'b0;
    logic [39:0]        m_axis_tdata;

    sieve_sums   sums = new();
    int unsigned cycle_count   = 0;
    bit          hold_request  = 1'b0;  // raised by stimulus, taken by receiver
    int          burst_left    = 0;

    prime_sieve_sum_query_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Give up on a hung block
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side: stall pattern, long hold-off on request, and checking
    // ------------------------------------------------------------------------
    t_rx_mode    rx_mode     = RX_OPEN;
    int unsigned mode_left   = 0;
    int unsigned hold_left   = 0;
    int unsigned beat_phase  = 0;

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else if (hold_request) begin
            // Hold off long enough for the block to back up into its query side
            hold_request = 1'b0;
            hold_left    = HOLD_LEN - 1;
            m_axis_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(32, 256);
            end
            mode_left--;
            case (rx_mode)
                RX_OPEN:   m_axis_tready <= 1'b1;
                RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_axis_tready <= ($urandom_range(0, 7) == 0);
                default: begin
                    m_axis_tready <= (beat_phase < 2);
                    beat_phase = (beat_phase == 4) ? 0 : beat_phase + 1;
                end
            endcase
        end
    end

    // Check every result transfer against the oldest owed sum
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sums.check_result(m_axis_tdata);
    end

    // ------------------------------------------------------------------------
    // Query side
    // ------------------------------------------------------------------------
    // Offer one query and hold it until transferred; then, at the end of a
    // burst, drop valid for a random gap, sometimes none, unless idling is barred.
    task automatic offer_query(int unsigned count, bit idle_ok = 1'b1);
        int unsigned gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= 16'(count[COUNT_W-1:0]);
        do @(posedge i_clk); while (!s_axis_tready);
        sums.note_query(count[COUNT_W-1:0]);
        if (!idle_ok)
            return;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic end_burst();
        s_axis_tvalid <= 1'b0;
    endtask

    // Wait until every owed sum has come back
    task automatic drain();
        while (sums.pending() != 0)
            @(posedge i_clk);
    endtask

    // Write the limit only with the block idle
    task automatic write_limit(int unsigned value);
        end_burst();
        drain();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[LIMIT_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sums.write_limit(value[LIMIT_W-1:0]);
    endtask

    // Mostly short counts; long walks and over-asks now and then
    function automatic int unsigned pick_count();
        case ($urandom_range(0, 19))
            0:       return 0;
            1:       return COUNT_MAX;
            2, 3:    return $urandom_range(0, COUNT_MAX);
            4, 5, 6: return $urandom_range(0, 700);
            default: return $urandom_range(0, 40);
        endcase
    endfunction

    function automatic int unsigned pick_limit(int phase);
        case (phase)
            0:       return MAX_LIMIT_DEF;
            1:       return $urandom_range(2, 200);
            2:       return $urandom_range(0, LIMIT_MAX);
            3:       return LIMIT_MAX;
            4:       return $urandom_range(200, MAX_LIMIT_DEF);
            5:       return 2;
            default: return $urandom_range(0, 64);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int phase;
        int n;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset limit: zero count, tiny counts, the largest count, and counts
        // around the number of primes below 4096 (564)
        offer_query(0);
        offer_query(1);
        offer_query(2);
        offer_query(COUNT_MAX);
        offer_query(564);
        offer_query(565);

        // No primes below limits of 0 and 1; zero count stays clean
        write_limit(0);
        offer_query(0);
        offer_query(5);
        write_limit(1);
        offer_query(1);
        offer_query(0);

        // Smallest limits that leave nothing, a single prime or two primes
        write_limit(2);
        offer_query(1);
        write_limit(3);
        offer_query(1);
        offer_query(2);
        write_limit(5);
        offer_query(2);
        offer_query(3);

        // Limit above the cap behaves as the cap
        write_limit(LIMIT_MAX);
        offer_query(COUNT_MAX);
        offer_query(564);

        // Rewriting the same value must still force a rebuild
        write_limit(MAX_LIMIT_DEF);
        offer_query(3);
        write_limit(MAX_LIMIT_DEF);
        offer_query(3);

        // Back-pressure: hold results off while queries keep coming
        write_limit(60);
        hold_request = 1'b1;
        repeat (10)
            offer_query($urandom_range(0, 20), 1'b0);
        end_burst();
        drain();
        @(posedge i_clk);

        // Random phases, each at a fresh limit
        for (phase = 0; phase < 7; phase++) begin
            write_limit(pick_limit(phase));
            for (n = 0; n < 16; n++) begin
                offer_query(pick_count());
                if ($urandom_range(0, 24) == 0) begin
                    // Pause until the block has handed back everything
                    end_burst();
                    drain();
                    @(posedge i_clk);
                end
            end
        end

        end_burst();
        drain();
        repeat (TAIL_LEN) @(posedge i_clk);
        if (sums.n_errors == 0 && sums.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
